/* src/iida_pkg.sv */
// Shared constants, types and codes for the indexed insert/delete array.
package iida_pkg;

    localparam int DEPTH         = 16;
    localparam int ELEMENT_WIDTH = 32;
    localparam int POS_W         = 5;
    localparam int COUNT_W       = 5;
    localparam int IDX_W         = $clog2(DEPTH);

    typedef logic [ELEMENT_WIDTH-1:0] elem_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic [COUNT_W-1:0]       count_t;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_WRITE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic  ins;
        logic  rem;
        logic  wr;
        pos_t  pos;
        elem_t value;
    } cell_ctrl_t;

endpackage

/* src/iida_cell.sv */
// One storage cell of the array chain; shifts with its neighbors on insert and remove.
module iida_cell
(
    input  logic                clk,
    input  iida_pkg::cell_ctrl_t ctrl,
    input  iida_pkg::pos_t      idx,
    input  iida_pkg::elem_t     lower_data,
    input  iida_pkg::elem_t     upper_data,
    output iida_pkg::elem_t     data
);

    iida_pkg::elem_t data_reg;
    iida_pkg::elem_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (idx > ctrl.pos)
            begin
                data_next = lower_data;
            end
            else if (idx == ctrl.pos)
            begin
                data_next = ctrl.value;
            end
        end
        else if (ctrl.rem)
        begin
            if (idx >= ctrl.pos)
            begin
                data_next = upper_data;
            end
        end
        else if (ctrl.wr)
        begin
            if (idx == ctrl.pos)
            begin
                data_next = ctrl.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* src/indexed_insert_delete_array_top.sv */
// Top level of the indexed insert/delete array: control, cell chain and result register.
//
// Usage:
//   Input channel (in_valid, in_stall, func, position, value) takes one
//   operation per beat: insert, remove, read or overwrite at an index.
//   Output channel (out_valid, out_stall, status, read_value, count) gives
//   one result beat per operation, in order.
//   The result of an accepted beat is registered at the edge that accepts
//   it and held until taken. Throughput is one operation per cycle while
//   the output is not stalled; every cell of the chain shifts with its
//   neighbor in the same cycle, so insert and remove are as fast as read
//   and write. While a result waits and out_stall is high, in_stall is
//   high and no new operation is taken; a result taken in a cycle frees
//   the input in that same cycle.
//   Reset empties the array (fill count zero) and clears the output valid
//   flag; the count output register is not reset. Cell contents are not
//   cleared; positions at or above the count are never read.
module indexed_insert_delete_array_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [4:0]  position,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] read_value,
    output logic [4:0]  count
);

    logic                  out_valid_reg;
    iida_pkg::status_t     status_reg;
    iida_pkg::elem_t       read_value_reg;
    iida_pkg::count_t      count_reg;
    iida_pkg::count_t      fill_reg;

    iida_pkg::status_t     status_next;
    iida_pkg::elem_t       read_value_next;
    iida_pkg::count_t      fill_next;
    iida_pkg::cell_ctrl_t  ctrl;
    iida_pkg::elem_t       cell_data [iida_pkg::DEPTH];
    iida_pkg::op_t         op;
    logic                  accept;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign op       = iida_pkg::op_t'(func);

    always_comb
    begin
        status_next     = iida_pkg::ST_OK;
        read_value_next = '0;
        fill_next       = fill_reg;
        ctrl.ins        = 1'b0;
        ctrl.rem        = 1'b0;
        ctrl.wr         = 1'b0;
        ctrl.pos        = position;
        ctrl.value      = value[iida_pkg::ELEMENT_WIDTH-1:0];
        case (op)
            iida_pkg::OP_INSERT:
            begin
                if (position > fill_reg)
                begin
                    status_next = iida_pkg::ST_RANGE;
                end
                else if (fill_reg == iida_pkg::COUNT_W'(iida_pkg::DEPTH))
                begin
                    status_next = iida_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.ins  = accept;
                    fill_next = fill_reg + 1'b1;
                end
            end
            iida_pkg::OP_REMOVE:
            begin
                if (position >= fill_reg)
                begin
                    status_next = iida_pkg::ST_RANGE;
                end
                else
                begin
                    ctrl.rem  = accept;
                    fill_next = fill_reg - 1'b1;
                end
            end
            iida_pkg::OP_READ:
            begin
                if (position >= fill_reg)
                begin
                    status_next = iida_pkg::ST_RANGE;
                end
                else
                begin
                    read_value_next = cell_data[position[iida_pkg::IDX_W-1:0]];
                end
            end
            iida_pkg::OP_WRITE:
            begin
                if (position >= fill_reg)
                begin
                    status_next = iida_pkg::ST_RANGE;
                end
                else
                begin
                    ctrl.wr = accept;
                end
            end
            default:
            begin
                status_next = iida_pkg::ST_RANGE;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < iida_pkg::DEPTH; g++)
        begin : g_cell
            iida_pkg::elem_t lower_data;
            iida_pkg::elem_t upper_data;
            if (g == 0)
            begin : g_first
                assign lower_data = cell_data[g];
            end
            else
            begin : g_mid_lo
                assign lower_data = cell_data[g-1];
            end
            if (g == iida_pkg::DEPTH - 1)
            begin : g_last
                assign upper_data = cell_data[g];
            end
            else
            begin : g_mid_hi
                assign upper_data = cell_data[g+1];
            end
            iida_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .idx        (iida_pkg::POS_W'(g)),
                .lower_data (lower_data),
                .upper_data (upper_data),
                .data       (cell_data[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fill_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                fill_reg      <= fill_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
            count_reg      <= fill_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = 32'(read_value_reg);
    assign count      = count_reg;

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the indexed insert/delete array: queued stimulus, predictor, checker.
module testbench;

    localparam int STALL_LIMIT = 1000;
    localparam int QUIET_TAIL  = 60;

    typedef struct {
        iida_pkg::op_t  op;
        iida_pkg::pos_t pos;
        logic [31:0]    val;
        bit             drain;
    } op_item_t;

    typedef struct {
        iida_pkg::status_t st;
        iida_pkg::elem_t   rd;
        iida_pkg::count_t  cnt;
    } op_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = iida_pkg::OP_INSERT;
    logic [4:0]  position = '0;
    logic [31:0] value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [4:0]  count;

    op_item_t   op_queue[$];
    op_result_t result_queue[$];

    iida_pkg::elem_t array_mem[iida_pkg::DEPTH];
    int    array_fill = 0;
    int    plan_fill = 0;

    bit in_took = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;
    int idle_cycles = 0;
    int beats_in = 0;
    int total_ops = 0;
    int errors = 0;
    int op_seen[4] = '{default: 0};
    int status_seen[3] = '{default: 0};

    indexed_insert_delete_array_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .read_value (read_value),
        .count      (count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic op_result_t apply_op(iida_pkg::op_t op, iida_pkg::pos_t pos,
                                            iida_pkg::elem_t val);
        op_result_t r;
        int i;
        r.st = iida_pkg::ST_OK;
        r.rd = '0;
        case (op)
            iida_pkg::OP_INSERT:
            begin
                if (pos > array_fill)
                    r.st = iida_pkg::ST_RANGE;
                else if (array_fill >= iida_pkg::DEPTH)
                    r.st = iida_pkg::ST_FULL;
                else
                begin
                    for (i = array_fill; i > pos; i--)
                        array_mem[i] = array_mem[i-1];
                    array_mem[pos] = val;
                    array_fill++;
                end
            end
            iida_pkg::OP_REMOVE:
            begin
                if (pos >= array_fill)
                    r.st = iida_pkg::ST_RANGE;
                else
                begin
                    for (i = pos; i + 1 < array_fill; i++)
                        array_mem[i] = array_mem[i+1];
                    array_fill--;
                end
            end
            iida_pkg::OP_READ:
            begin
                if (pos >= array_fill)
                    r.st = iida_pkg::ST_RANGE;
                else
                    r.rd = array_mem[pos];
            end
            default:
            begin
                if (pos >= array_fill)
                    r.st = iida_pkg::ST_RANGE;
                else
                    array_mem[pos] = val;
            end
        endcase
        r.cnt = iida_pkg::count_t'(array_fill);
        return r;
    endfunction

    task automatic queue_op(iida_pkg::op_t op, int pos, logic [31:0] val, bit drain);
        op_item_t it;
        it.op = op;
        it.pos = iida_pkg::pos_t'(pos);
        it.val = val;
        it.drain = drain;
        op_queue.push_back(it);
        if (op == iida_pkg::OP_INSERT && pos <= plan_fill && plan_fill < iida_pkg::DEPTH)
            plan_fill++;
        else if (op == iida_pkg::OP_REMOVE && pos < plan_fill)
            plan_fill--;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // send side: hold the beat while stalled, advance once taken; also drives out_stall
    always @(negedge clk)
    begin
        op_item_t it;
        bit quiet;
        if (rst_n)
        begin
            quiet = (op_queue.size() < QUIET_TAIL);
            if (!in_valid || in_took)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (op_queue.size() == 0)
                    in_valid <= 1'b0;
                else if (op_queue[0].drain && result_queue.size() != 0)
                    in_valid <= 1'b0;
                else if (!quiet && $urandom_range(0, 15) == 0)
                begin
                    send_gap = $urandom_range(0, 17);
                    in_valid <= 1'b0;
                end
                else
                begin
                    it = op_queue.pop_front();
                    func <= it.op;
                    position <= it.pos;
                    value <= it.val;
                    in_valid <= 1'b1;
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                recv_gap = $urandom_range(0, 17);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // receive side: check the result beat first, then predict the new beat
    always @(posedge clk)
    begin
        op_result_t want;
        bit in_fire;
        bit out_fire;
        if (rst_n)
        begin
            in_fire = in_valid && !in_stall;
            out_fire = out_valid && !out_stall;
            in_took <= in_fire;
            if (out_fire)
            begin
                if (status <= iida_pkg::ST_FULL)
                    status_seen[status]++;
                if (result_queue.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected (status %0d count %0d)",
                             $time, status, count);
                    errors++;
                end
                else
                begin
                    want = result_queue.pop_front();
                    if (status !== want.st)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.st, status);
                        errors++;
                    end
                    if (read_value !== 32'(want.rd))
                    begin
                        $display("%0t: read_value mismatch, expected %h, got %h",
                                 $time, 32'(want.rd), read_value);
                        errors++;
                    end
                    if (count !== want.cnt)
                    begin
                        $display("%0t: count mismatch, expected %0d, got %0d",
                                 $time, want.cnt, count);
                        errors++;
                    end
                end
            end
            if (in_fire)
            begin
                result_queue.push_back(apply_op(iida_pkg::op_t'(func), position,
                                                iida_pkg::elem_t'(value)));
                op_seen[func]++;
                beats_in++;
            end
            if (in_fire || out_fire)
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("%0t: no beat for %0d cycles, %0d results outstanding",
                             $time, STALL_LIMIT, result_queue.size());
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        int n;
        int r;
        int pos;
        bit grow;
        iida_pkg::op_t op;

        // empty array: every access is out of range
        queue_op(iida_pkg::OP_READ, 0, 32'h0, 1'b0);
        queue_op(iida_pkg::OP_REMOVE, 0, 32'h0, 1'b0);
        queue_op(iida_pkg::OP_WRITE, 0, 32'h1234_5678, 1'b0);
        queue_op(iida_pkg::OP_INSERT, 1, 32'h1, 1'b0);
        queue_op(iida_pkg::OP_INSERT, 16, 32'h2, 1'b0);
        // append, prepend, middle, then fill up and try accesses at the full array's edges
        queue_op(iida_pkg::OP_INSERT, 0, 32'h0000_0000, 1'b0);
        queue_op(iida_pkg::OP_INSERT, 1, 32'hFFFF_FFFF, 1'b0);
        queue_op(iida_pkg::OP_INSERT, 0, 32'hA5A5_A5A5, 1'b0);
        queue_op(iida_pkg::OP_INSERT, 1, $urandom, 1'b0);
        while (plan_fill < iida_pkg::DEPTH)
            queue_op(iida_pkg::OP_INSERT, $urandom_range(0, plan_fill), $urandom, 1'b0);
        queue_op(iida_pkg::OP_INSERT, 16, 32'h3, 1'b0);
        queue_op(iida_pkg::OP_INSERT, 0, 32'h4, 1'b0);
        queue_op(iida_pkg::OP_READ, 15, 32'h0, 1'b0);
        queue_op(iida_pkg::OP_READ, 16, 32'h0, 1'b0);
        queue_op(iida_pkg::OP_WRITE, 15, 32'h5A5A_5A5A, 1'b0);
        queue_op(iida_pkg::OP_WRITE, 16, 32'h6, 1'b0);
        queue_op(iida_pkg::OP_REMOVE, 16, 32'h0, 1'b0);
        queue_op(iida_pkg::OP_REMOVE, 15, 32'h0, 1'b0);
        queue_op(iida_pkg::OP_REMOVE, 0, 32'h0, 1'b0);
        queue_op(iida_pkg::OP_READ, 0, 32'h0, 1'b0);

        grow = 1'b1;
        for (n = 0; n < 450; n++)
        begin
            if (n % 40 == 0)
                grow = (plan_fill < 4) ? 1'b1 : (plan_fill > 12) ? 1'b0 :
                       $urandom_range(0, 1);
            r = $urandom_range(0, 99);
            if (grow)
                op = (r < 45) ? iida_pkg::OP_INSERT : (r < 60) ? iida_pkg::OP_REMOVE :
                     (r < 80) ? iida_pkg::OP_READ : iida_pkg::OP_WRITE;
            else
                op = (r < 15) ? iida_pkg::OP_INSERT : (r < 55) ? iida_pkg::OP_REMOVE :
                     (r < 78) ? iida_pkg::OP_READ : iida_pkg::OP_WRITE;
            if ($urandom_range(0, 9) == 0)
                pos = $urandom_range(0, 16);
            else if (op == iida_pkg::OP_INSERT)
                pos = $urandom_range(0, plan_fill);
            else if (plan_fill == 0)
                pos = $urandom_range(0, 16);
            else
                pos = $urandom_range(0, plan_fill - 1);
            queue_op(op, pos, pick_value(), (n == 0 || n == 225));
        end
        total_ops = op_queue.size();

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        while (beats_in != total_ops)
            @(negedge clk);
        while (result_queue.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);

        $display("Ran %0d operations: %0d insert, %0d remove, %0d read, %0d overwrite.",
                 beats_in, op_seen[iida_pkg::OP_INSERT], op_seen[iida_pkg::OP_REMOVE],
                 op_seen[iida_pkg::OP_READ], op_seen[iida_pkg::OP_WRITE]);
        $display("Results by status: %0d ok, %0d out of range, %0d full; %0d mismatches.",
                 status_seen[iida_pkg::ST_OK], status_seen[iida_pkg::ST_RANGE],
                 status_seen[iida_pkg::ST_FULL], errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
